[rtl/core/alct_pkg.sv]
// Package for the alarm clock timekeeper: beat payload types, mode bit
// positions, button and encoder codes, and time limits.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package alct_pkg;

    // Input beat: one timer tick with its button pulses and encoder event.
    typedef struct packed {
        logic [7:0] button_presses;
        logic [2:0] encoder_event;
    } in_t;

    // Result beat: the clock and alarm state after the tick.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       colon_lit;
        logic [3:0] mode_bits;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
    } out_t;

    // Positions of the bits in mode_bits.
    localparam int unsigned MODE_ARMED     = 0;
    localparam int unsigned MODE_SNOOZING  = 1;
    localparam int unsigned MODE_TIME_SET  = 2;
    localparam int unsigned MODE_ALARM_SET = 3;

    // Single-button press patterns that act.
    localparam logic [7:0] BTN_ALARM_SET = 8'h01;
    localparam logic [7:0] BTN_ARMED     = 8'h02;
    localparam logic [7:0] BTN_SNOOZING  = 8'h04;
    localparam logic [7:0] BTN_TIME_SET  = 8'h08;

    // Encoder event codes.
    localparam logic [2:0] ENC_NONE        = 3'd0;
    localparam logic [2:0] ENC_HOUR_DOWN   = 3'd1;
    localparam logic [2:0] ENC_HOUR_UP     = 3'd2;
    localparam logic [2:0] ENC_MINUTE_DOWN = 3'd3;
    localparam logic [2:0] ENC_MINUTE_UP   = 3'd4;

    // Time limits.
    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
    localparam logic [4:0] HOUR_TOP           = 5'd23;
    localparam logic [5:0] MINUTE_TOP         = 6'd59;

    // Prescaler.
    localparam int unsigned  TPS_WIDTH = 16;
    localparam logic [15:0]  TPS_RESET = 16'd512;

endpackage

`default_nettype wire

[rtl/core/alarm_clock_timekeeper.sv]
// Top level of the alarm clock timekeeper: input register, clock and alarm
// state, result register and the ticks_per_second register.
// Depends on alct_pkg and alct_step.
//
// Usage. Each input beat on in_valid/in_ready/in_data is one timer tick
// carrying debounced button pulses and an encoder event. Each tick yields
// exactly one result beat on out_valid/out_ready/out_data holding hours,
// minutes, seconds, colon, mode bits and the alarm setting as they stand
// after that tick.
// The tick is captured in the input register, and the step logic's result is
// then loaded into the state and the result register together. Throughput is
// one tick per cycle while the receiver takes each result; the state update is
// a single pass of counter logic.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more tick, and in_ready drops only once both are full;
// no tick is lost or processed twice.
// Reset clears the time, alarm, mode bits and prescaler to zero, sets
// ticks_per_second to 512 and empties both registers. cfg_we writes
// ticks_per_second; write it only while no tick is in flight.
`default_nettype none

module alarm_clock_timekeeper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire alct_pkg::in_t                      in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output alct_pkg::out_t                          out_data,
    input  wire logic                               cfg_we,
    input  wire logic [alct_pkg::TPS_WIDTH-1:0]     cfg_wdata
);

    // Configuration.
    logic [alct_pkg::TPS_WIDTH-1:0] tps_reg;

    // Input register.
    logic           in_valid_reg;
    alct_pkg::in_t  in_data_reg;

    // Architectural state: time, mode and alarm plus the prescaler count.
    alct_pkg::out_t                 state_reg;
    alct_pkg::out_t                 state_next;
    logic [alct_pkg::TPS_WIDTH-1:0] count_reg;
    logic [alct_pkg::TPS_WIDTH-1:0] count_next;

    // Result register.
    logic           out_valid_reg;
    alct_pkg::out_t out_data_reg;

    // A tick is processed when it sits in the input register and the result
    // register is empty or is being emptied in this cycle.
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    alct_step u_step (
        .cur_state        (state_reg),
        .cur_count        (count_reg),
        .ticks_per_second (tps_reg),
        .item             (in_data_reg),
        .next_state       (state_next),
        .next_count       (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= alct_pkg::TPS_RESET;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // State moves only when a tick is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= state_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/alct_step.sv]
// Next-state logic for one tick of the alarm clock timekeeper: prescaler,
// time rollover, mode button toggles and encoder adjustment.
// Depends on alct_pkg.
`default_nettype none

module alct_step (
    input  wire alct_pkg::out_t                   cur_state,
    input  wire logic [alct_pkg::TPS_WIDTH-1:0]   cur_count,
    input  wire logic [alct_pkg::TPS_WIDTH-1:0]   ticks_per_second,
    input  wire alct_pkg::in_t                    item,
    output alct_pkg::out_t                        next_state,
    output logic [alct_pkg::TPS_WIDTH-1:0]        next_count
);

    alct_pkg::out_t s;
    logic [alct_pkg::TPS_WIDTH-1:0] cnt;
    logic       target_clock;
    logic       target_alarm;
    logic [4:0] h;
    logic [5:0] m;

    always_comb
    begin
        s   = cur_state;
        cnt = cur_count;

        // Prescaler and rollover run only while time-set mode is off.
        if (!cur_state.mode_bits[alct_pkg::MODE_TIME_SET])
        begin
            cnt = cur_count + {{(alct_pkg::TPS_WIDTH-1){1'b0}}, 1'b1};
            // A rate of zero makes every tick a second, as does a count
            // left above a newly lowered rate.
            if (cnt >= ticks_per_second)
            begin
                cnt         = '0;
                s.seconds   = s.seconds + 6'd1;
                s.colon_lit = ~s.colon_lit;
            end
            if (s.seconds >= alct_pkg::SECONDS_PER_MINUTE)
            begin
                s.seconds = '0;
                s.minutes = s.minutes + 6'd1;
            end
            if (s.minutes >= alct_pkg::MINUTES_PER_HOUR)
            begin
                s.minutes = '0;
                s.hours   = s.hours + 5'd1;
            end
            if (s.hours >= alct_pkg::HOURS_PER_DAY)
            begin
                s.hours = '0;
            end
        end

        // Only a press of exactly one of the four low buttons acts.
        unique case (item.button_presses)
            alct_pkg::BTN_ALARM_SET:
                s.mode_bits[alct_pkg::MODE_ALARM_SET] = ~s.mode_bits[alct_pkg::MODE_ALARM_SET];
            alct_pkg::BTN_ARMED:
                s.mode_bits[alct_pkg::MODE_ARMED] = ~s.mode_bits[alct_pkg::MODE_ARMED];
            alct_pkg::BTN_SNOOZING:
                s.mode_bits[alct_pkg::MODE_SNOOZING] = ~s.mode_bits[alct_pkg::MODE_SNOOZING];
            alct_pkg::BTN_TIME_SET:
                s.mode_bits[alct_pkg::MODE_TIME_SET] = ~s.mode_bits[alct_pkg::MODE_TIME_SET];
            default:
                ;
        endcase

        // The encoder sees the mode after this tick's button update. Time-set
        // mode wins over alarm-set mode.
        target_clock = s.mode_bits[alct_pkg::MODE_TIME_SET];
        target_alarm = !target_clock && s.mode_bits[alct_pkg::MODE_ALARM_SET];
        h = target_clock ? s.hours   : s.alarm_hours;
        m = target_clock ? s.minutes : s.alarm_minutes;

        unique case (item.encoder_event)
            alct_pkg::ENC_HOUR_DOWN:
                h = (h == 5'd0 || h > alct_pkg::HOUR_TOP) ? alct_pkg::HOUR_TOP : h - 5'd1;
            alct_pkg::ENC_HOUR_UP:
                h = (h >= alct_pkg::HOUR_TOP) ? 5'd0 : h + 5'd1;
            alct_pkg::ENC_MINUTE_DOWN:
                m = (m == 6'd0 || m > alct_pkg::MINUTE_TOP) ? alct_pkg::MINUTE_TOP : m - 6'd1;
            alct_pkg::ENC_MINUTE_UP:
                m = (m >= alct_pkg::MINUTE_TOP) ? 6'd0 : m + 6'd1;
            default:
                ;
        endcase

        if (target_clock)
        begin
            s.hours   = h;
            s.minutes = m;
        end
        else if (target_alarm)
        begin
            s.alarm_hours   = h;
            s.alarm_minutes = m;
        end

        next_state = s;
        next_count = cnt;
    end

endmodule

`default_nettype wire

[bench/alarm_clock_timekeeper_tb.sv]
// Self-checking testbench for alarm_clock_timekeeper: directed and random tick beats
// are checked against a cycle-free predictor of the clock, mode and alarm state.
// Depends on alct_pkg and the alarm_clock_timekeeper RTL.
`timescale 1ns / 1ps

module alarm_clock_timekeeper_tb;

    // The run is cut off here if the handshakes ever stop moving.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Cycles waited after the last reading is in, to be sure that nothing is
    // still on its way.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [7:0]  NO_BUTTONS    = 8'h00;
    localparam logic [2:0]  ENC_LAST_CODE = 3'd7;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    alct_pkg::in_t   in_data;
    logic            out_valid;
    logic            out_ready = 1'b0;
    alct_pkg::out_t  out_data;
    logic            cfg_we;
    logic [15:0]     cfg_wdata;

    // Percentages of cycles in which each side holds back.
    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 88;

    int unsigned mismatches = 0;
    int unsigned ticks_sent = 0;
    int unsigned cycle_count = 0;

    // Readings the block owes us, oldest first.
    alct_pkg::out_t pending_readings[$];

    // Our own copy of the block's state and of the ticks_per_second register.
    logic [15:0] rate_ticks = alct_pkg::TPS_RESET;
    logic [15:0] cnt_ticks = '0;
    logic [4:0]  cur_hour = '0;
    logic [5:0]  cur_minute = '0;
    logic [5:0]  cur_second = '0;
    logic        cur_colon = 1'b0;
    logic [3:0]  cur_mode = '0;
    logic [4:0]  set_alarm_hour = '0;
    logic [5:0]  set_alarm_minute = '0;

    alarm_clock_timekeeper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one tick to the predicted state and returns the reading the block
    // must show afterwards. The three steps run in the block's order: the
    // prescaler, then the buttons, then the encoder, which therefore already
    // sees a mode bit toggled by a button in the same tick.
    function automatic alct_pkg::out_t next_reading(input alct_pkg::in_t beat);
        alct_pkg::out_t reading;
        logic [4:0]     knob_hour;
        logic [5:0]     knob_minute;
        logic           on_clock;
        logic           on_alarm;

        // The prescaler is frozen while the time is being set. A rate of zero
        // makes every counting tick a full second, and a rate written below
        // the current count finishes the second on the next counting tick.
        if (!cur_mode[alct_pkg::MODE_TIME_SET])
        begin
            cnt_ticks = cnt_ticks + 16'd1;
            if (cnt_ticks >= rate_ticks)
            begin
                cnt_ticks  = '0;
                cur_second = cur_second + 6'd1;
                cur_colon  = ~cur_colon;
            end
            if (cur_second >= alct_pkg::SECONDS_PER_MINUTE)
            begin
                cur_second = '0;
                cur_minute = cur_minute + 6'd1;
            end
            if (cur_minute >= alct_pkg::MINUTES_PER_HOUR)
            begin
                cur_minute = '0;
                cur_hour   = cur_hour + 5'd1;
            end
            if (cur_hour >= alct_pkg::HOURS_PER_DAY)
                cur_hour = '0;
        end

        // Only a press of exactly one of the four low buttons does anything;
        // combined presses and any upper button are ignored.
        case (beat.button_presses)
            alct_pkg::BTN_ALARM_SET:
                cur_mode[alct_pkg::MODE_ALARM_SET] = ~cur_mode[alct_pkg::MODE_ALARM_SET];
            alct_pkg::BTN_ARMED:
                cur_mode[alct_pkg::MODE_ARMED] = ~cur_mode[alct_pkg::MODE_ARMED];
            alct_pkg::BTN_SNOOZING:
                cur_mode[alct_pkg::MODE_SNOOZING] = ~cur_mode[alct_pkg::MODE_SNOOZING];
            alct_pkg::BTN_TIME_SET:
                cur_mode[alct_pkg::MODE_TIME_SET] = ~cur_mode[alct_pkg::MODE_TIME_SET];
            default: ;
        endcase

        // With both set modes on, the knob moves the clock and not the alarm.
        on_clock = cur_mode[alct_pkg::MODE_TIME_SET];
        on_alarm = !on_clock && cur_mode[alct_pkg::MODE_ALARM_SET];
        knob_hour   = on_clock ? cur_hour : set_alarm_hour;
        knob_minute = on_clock ? cur_minute : set_alarm_minute;
        case (beat.encoder_event)
            alct_pkg::ENC_HOUR_DOWN:
                knob_hour = (knob_hour == 5'd0 || knob_hour > alct_pkg::HOUR_TOP) ?
                            alct_pkg::HOUR_TOP : knob_hour - 5'd1;
            alct_pkg::ENC_HOUR_UP:
                knob_hour = (knob_hour >= alct_pkg::HOUR_TOP) ?
                            5'd0 : knob_hour + 5'd1;
            alct_pkg::ENC_MINUTE_DOWN:
                knob_minute = (knob_minute == 6'd0 || knob_minute > alct_pkg::MINUTE_TOP) ?
                              alct_pkg::MINUTE_TOP : knob_minute - 6'd1;
            alct_pkg::ENC_MINUTE_UP:
                knob_minute = (knob_minute >= alct_pkg::MINUTE_TOP) ?
                              6'd0 : knob_minute + 6'd1;
            default: ;
        endcase
        if (on_clock)
        begin
            cur_hour   = knob_hour;
            cur_minute = knob_minute;
        end
        else if (on_alarm)
        begin
            set_alarm_hour   = knob_hour;
            set_alarm_minute = knob_minute;
        end

        reading.hours         = cur_hour;
        reading.minutes       = cur_minute;
        reading.seconds       = cur_second;
        reading.colon_lit     = cur_colon;
        reading.mode_bits     = cur_mode;
        reading.alarm_hours   = set_alarm_hour;
        reading.alarm_minutes = set_alarm_minute;
        return reading;
    endfunction

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reading(input alct_pkg::out_t got);
        alct_pkg::out_t want;
        if (pending_readings.size() == 0)
        begin
            $error("result beat with no tick waiting for it: %p", got);
            mismatches++;
        end
        else
        begin
            want = pending_readings.pop_front();
            compare_field("hours", 8'(want.hours), 8'(got.hours));
            compare_field("minutes", 8'(want.minutes), 8'(got.minutes));
            compare_field("seconds", 8'(want.seconds), 8'(got.seconds));
            compare_field("colon_lit", 8'(want.colon_lit), 8'(got.colon_lit));
            compare_field("mode_bits", 8'(want.mode_bits), 8'(got.mode_bits));
            compare_field("alarm_hours", 8'(want.alarm_hours), 8'(got.alarm_hours));
            compare_field("alarm_minutes", 8'(want.alarm_minutes),
                          8'(got.alarm_minutes));
        end
    endtask

    // Receiving side. Values are sampled as they stood before the edge, since
    // every testbench drive lands in the nonblocking region of the same step.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_reading(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sends one tick beat after a random gap and predicts its reading once
    // the beat is taken. Valid is left high on return: the caller either sends
    // the next beat in the same step or lowers valid before time moves on.
    task automatic send_tick(input logic [7:0] buttons, input logic [2:0] code);
        alct_pkg::in_t beat;
        beat.button_presses = buttons;
        beat.encoder_event  = code;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_readings.push_back(next_reading(beat));
        ticks_sent++;
    endtask

    // Stops sending and waits until the block has paid out every reading.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The rate register is only written while no tick is in flight.
    task automatic set_rate(input logic [15:0] rate);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we     <= 1'b0;
        rate_ticks  = rate;
    endtask

    // The alarm-set, armed and snoozing buttons on their own, then patterns that
    // must be ignored: two low buttons together, an upper button alone and every button at once.
    task automatic test_mode_buttons();
        send_tick(alct_pkg::BTN_ALARM_SET, alct_pkg::ENC_NONE);
        send_tick(alct_pkg::BTN_ARMED, alct_pkg::ENC_NONE);
        send_tick(alct_pkg::BTN_SNOOZING, alct_pkg::ENC_NONE);
        send_tick(alct_pkg::BTN_ALARM_SET | alct_pkg::BTN_ARMED, alct_pkg::ENC_NONE);
        send_tick(8'h10, alct_pkg::ENC_NONE);
        send_tick(8'hFF, alct_pkg::ENC_NONE);
        send_tick(alct_pkg::BTN_ALARM_SET, alct_pkg::ENC_NONE);
    endtask

    // Encoder moves with no set mode, in time-set mode with both wraps in both
    // directions, with unknown codes, with both set modes on, and in alarm-set
    // mode alone. Several ticks press a button together with the knob.
    task automatic test_encoder_targets();
        int code;
        send_tick(NO_BUTTONS, alct_pkg::ENC_HOUR_DOWN);
        send_tick(alct_pkg::BTN_TIME_SET, alct_pkg::ENC_HOUR_DOWN);
        send_tick(NO_BUTTONS, alct_pkg::ENC_HOUR_UP);
        send_tick(NO_BUTTONS, alct_pkg::ENC_MINUTE_DOWN);
        send_tick(NO_BUTTONS, alct_pkg::ENC_MINUTE_UP);
        send_tick(NO_BUTTONS, alct_pkg::ENC_MINUTE_DOWN);
        for (code = int'(alct_pkg::ENC_MINUTE_UP) + 1; code <= int'(ENC_LAST_CODE); code++)
            send_tick(NO_BUTTONS, 3'(code));
        send_tick(alct_pkg::BTN_ALARM_SET, alct_pkg::ENC_HOUR_UP);
        send_tick(alct_pkg::BTN_TIME_SET, alct_pkg::ENC_MINUTE_DOWN);
        send_tick(NO_BUTTONS, alct_pkg::ENC_HOUR_DOWN);
        send_tick(NO_BUTTONS, alct_pkg::ENC_MINUTE_UP);
        send_tick(alct_pkg::BTN_ALARM_SET, alct_pkg::ENC_NONE);
    endtask

    // The count is well above two by now, so lowering the rate to two has
    // to finish a second on the very next tick. A rate of zero gives one
    // second per tick, and the widest rate holds the seconds still.
    task automatic test_prescaler_rate();
        set_rate(16'd2);
        repeat (2) send_tick(NO_BUTTONS, alct_pkg::ENC_NONE);
        set_rate(16'd0);
        repeat (3) send_tick(NO_BUTTONS, alct_pkg::ENC_NONE);
        set_rate(16'hFFFF);
        repeat (2) send_tick(NO_BUTTONS, alct_pkg::ENC_NONE);
    endtask

    // Enters a set mode unless it is already on, turns the knob a few times
    // and leaves it again.
    task automatic knob_session(input bit on_clock);
        int unsigned mode_bit;
        logic [7:0]  button;
        mode_bit = on_clock ? alct_pkg::MODE_TIME_SET : alct_pkg::MODE_ALARM_SET;
        button   = on_clock ? alct_pkg::BTN_TIME_SET : alct_pkg::BTN_ALARM_SET;
        if (!cur_mode[mode_bit])
            send_tick(button,
                      3'($urandom_range(alct_pkg::ENC_NONE, alct_pkg::ENC_MINUTE_UP)));
        repeat ($urandom_range(1, 12))
            send_tick(NO_BUTTONS,
                      3'($urandom_range(alct_pkg::ENC_HOUR_DOWN, alct_pkg::ENC_MINUTE_UP)));
        if (cur_mode[mode_bit])
            send_tick(button, alct_pkg::ENC_NONE);
    endtask

    // Sets the clock to 23:59 the short way round, so that the counting that
    // follows carries seconds through minutes and hours back to midnight.
    task automatic approach_midnight();
        if (!cur_mode[alct_pkg::MODE_TIME_SET])
            send_tick(alct_pkg::BTN_TIME_SET, alct_pkg::ENC_NONE);
        while (cur_hour != alct_pkg::HOUR_TOP)
            send_tick(NO_BUTTONS, (cur_hour >= 5'd12) ?
                      alct_pkg::ENC_HOUR_UP : alct_pkg::ENC_HOUR_DOWN);
        while (cur_minute != alct_pkg::MINUTE_TOP)
            send_tick(NO_BUTTONS, (cur_minute >= 6'd30) ?
                      alct_pkg::ENC_MINUTE_UP : alct_pkg::ENC_MINUTE_DOWN);
        send_tick(alct_pkg::BTN_TIME_SET, alct_pkg::ENC_NONE);
    endtask

    // Mostly well-formed use: stretches of plain ticks, set sessions and
    // single button presses, with a share of fully random beats as noise.
    task automatic run_random_ticks(input int unsigned count);
        int unsigned pick;
        ticks_sent = 0;
        while (ticks_sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                repeat ($urandom_range(1, 24)) send_tick(NO_BUTTONS, alct_pkg::ENC_NONE);
            else if (pick < 58)
                knob_session(1'($urandom_range(0, 1)));
            else if (pick < 63)
                approach_midnight();
            else if (pick < 80)
                send_tick(alct_pkg::BTN_ALARM_SET << $urandom_range(0, 3),
                          3'($urandom_range(alct_pkg::ENC_NONE, alct_pkg::ENC_MINUTE_UP)));
            else
                send_tick(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        end
    endtask

    // One idling setting with two rates, each holding for about a sixth of
    // the random ticks. Every rate change lets the block run dry first.
    task automatic test_random_ticks(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [15:0] first_rate,
                                     input logic [15:0] second_rate);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_rate(first_rate);
        run_random_ticks(250);
        set_rate(second_rate);
        run_random_ticks(250);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part starts at the reset rate and runs with the first idling
        // setting: a sender that gaps now and then and a slow receiver.
        test_mode_buttons();
        test_encoder_targets();
        test_prescaler_rate();

        // The widest rate is followed by a small one, so that the count built
        // up under it lands above the new rate once more.
        test_random_ticks(36, 88, 16'd1, 16'd3);
        test_random_ticks(88, 36, 16'hFFFF, 16'd2);
        test_random_ticks(0, 0, 16'd1, 16'd4);

        wait_for_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
